>>> rtl/mbrot_pkg.sv
// Shared types, constants and helpers for the Mandelbrot escape-time unit.
// Used by mbrot_ctrl, mbrot_datapath and mandelbrot_escape_test_unit; depends on nothing.
`default_nettype none

package mbrot_pkg;

   localparam int Q_W    = 32;          // width of a fixed point coordinate
   localparam int ITER_W = 10;          // width of the iteration limit and index
   localparam int ESC_W  = 11;          // width of the escape limit
   localparam int PROD_W = 2 * Q_W;     // exact product of two coordinates
   localparam int SUM_W  = PROD_W + 2;  // scaled product plus c, before saturation

   localparam int FRAC_BITS_DEFAULT = 20;

   localparam logic [ITER_W-1:0] ITER_LIMIT_RESET = ITER_W'(255);
   localparam logic [ESC_W-1:0]  ESC_LIMIT_RESET  = ESC_W'(400);

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = ESC_W;

   localparam logic [CSR_IDX_W-1:0] CSR_ITER_LIMIT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_ESC_LIMIT  = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL0,
      ST_UPD0,
      ST_MUL,
      ST_TEST,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load;         // latch c, clear z and the iteration index
      logic mul;          // register the three products of z
      logic update;       // take the new z
      logic count;        // advance the iteration index
      logic set_bounded;  // record a bounded result
      logic set_escaped;  // record an escape at the current index
      logic emit;         // move the result into the output register
   } cmd_type;

   typedef struct packed {
      logic escaped;      // squared magnitude of z exceeds the escape limit
      logic last_iter;    // current index is the final one allowed
      logic limit_zero;   // iteration limit is zero
   } status_type;

   // Clamp a widened sum to the signed coordinate range.
   function automatic logic signed [Q_W-1:0] sat_q(input logic signed [SUM_W-1:0] v);
      logic [SUM_W-Q_W:0] upper;
      upper = v[SUM_W-1:Q_W-1];
      if ((&upper) || !(|upper)) begin
         return v[Q_W-1:0];
      end else begin
         return {v[SUM_W-1], {(Q_W-1){~v[SUM_W-1]}}};
      end
   endfunction

endpackage

`default_nettype wire

>>> rtl/mbrot_ctrl.sv
// Sequencing state machine for the Mandelbrot escape-time unit.
// Depends on mbrot_pkg; drives the command struct of mbrot_datapath.
`default_nettype none

module mbrot_ctrl import mbrot_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   input  wire status_type status,
   output cmd_type         cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               if (status.limit_zero) begin
                  cmd.set_bounded = 1'b1;
                  state_in        = ST_EMIT;
               end else begin
                  state_in = ST_MUL0;
               end
            end
         end
         ST_MUL0: begin
            cmd.mul  = 1'b1;
            state_in = ST_UPD0;
         end
         // The starting z of zero is never tested, so the first update goes straight through.
         ST_UPD0: begin
            cmd.update = 1'b1;
            state_in   = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_TEST;
         end
         ST_TEST: begin
            if (status.escaped) begin
               cmd.set_escaped = 1'b1;
               state_in        = ST_EMIT;
            end else if (status.last_iter) begin
               cmd.set_bounded = 1'b1;
               state_in        = ST_EMIT;
            end else begin
               cmd.update = 1'b1;
               cmd.count  = 1'b1;
               state_in   = ST_MUL;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = cmd.emit || (rsp_valid_ff && !rsp_ready);
   assign rsp_valid    = rsp_valid_ff;

   // A test always works on products registered in the cycle before.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TEST) |-> ($past(state_ff) == ST_MUL))
      else $error("test state entered without a preceding multiply");

   // A result never overwrites one the receiver has not yet taken.
   assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid_ff || rsp_ready))
      else $error("output register overwritten before transfer");

   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_MUL0 || state_ff == ST_EMIT))
      else $error("accepted item did not start an iteration or finish");

endmodule

`default_nettype wire

>>> rtl/mbrot_datapath.sv
// Datapath of the Mandelbrot escape-time unit: configuration registers, z, products,
// escape compare, iteration index and result registers. Depends on mbrot_pkg.
`default_nettype none

module mbrot_datapath import mbrot_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_we,
   input  wire logic [CSR_IDX_W-1:0]   csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata,
   input  wire logic signed [Q_W-1:0]  req_c_real,
   input  wire logic signed [Q_W-1:0]  req_c_imag,
   input  wire cmd_type                cmd,
   output status_type                  status,
   output logic                        rsp_in_set,
   output logic [ITER_W-1:0]           rsp_stop_iteration
);

   localparam int LIM_SHIFT = 2 * FRAC_BITS;
   localparam int CMP_W     = (LIM_SHIFT + ESC_W > PROD_W + 1) ? LIM_SHIFT + ESC_W : PROD_W + 1;

   logic [ITER_W-1:0]        iter_limit_ff, iter_limit_in;
   logic [ESC_W-1:0]         esc_limit_ff, esc_limit_in;
   logic signed [Q_W-1:0]    c_r_ff, c_r_in, c_i_ff, c_i_in;
   logic signed [Q_W-1:0]    z_r_ff, z_r_in, z_i_ff, z_i_in;
   logic signed [PROD_W-1:0] p_rr_ff, p_rr_in, p_ii_ff, p_ii_in, p_ri_ff, p_ri_in;
   logic [ITER_W-1:0]        iter_ff, iter_in;
   logic                     res_in_set_ff, res_in_set_in;
   logic [ITER_W-1:0]        res_stop_ff, res_stop_in;
   logic                     out_in_set_ff, out_in_set_in;
   logic [ITER_W-1:0]        out_stop_ff, out_stop_in;

   logic signed [PROD_W:0]   re_diff, re_shift;
   logic signed [PROD_W-1:0] im_shift;
   logic signed [SUM_W-1:0]  re_sum, im_sum;
   logic signed [Q_W-1:0]    z_r_new, z_i_new;
   logic [PROD_W:0]          mag;
   logic [CMP_W-1:0]         mag_ext, lim_scaled;

   always_ff @(posedge clock) begin
      if (reset) begin
         iter_limit_ff <= ITER_LIMIT_RESET;
         esc_limit_ff  <= ESC_LIMIT_RESET;
      end else begin
         iter_limit_ff <= iter_limit_in;
         esc_limit_ff  <= esc_limit_in;
      end
   end

   always_ff @(posedge clock) begin
      c_r_ff        <= c_r_in;
      c_i_ff        <= c_i_in;
      z_r_ff        <= z_r_in;
      z_i_ff        <= z_i_in;
      p_rr_ff       <= p_rr_in;
      p_ii_ff       <= p_ii_in;
      p_ri_ff       <= p_ri_in;
      iter_ff       <= iter_in;
      res_in_set_ff <= res_in_set_in;
      res_stop_ff   <= res_stop_in;
      out_in_set_ff <= out_in_set_in;
      out_stop_ff   <= out_stop_in;
   end

   always_comb begin
      iter_limit_in = iter_limit_ff;
      esc_limit_in  = esc_limit_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_ITER_LIMIT: iter_limit_in = csr_wdata[ITER_W-1:0];
            CSR_ESC_LIMIT:  esc_limit_in  = csr_wdata[ESC_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Next z: products are scaled back with a flooring shift; twice zr*zi is one bit less shift.
   assign re_diff  = $signed({p_rr_ff[PROD_W-1], p_rr_ff}) - $signed({p_ii_ff[PROD_W-1], p_ii_ff});
   assign re_shift = re_diff >>> FRAC_BITS;
   assign im_shift = p_ri_ff >>> (FRAC_BITS - 1);
   assign re_sum   = $signed({re_shift[PROD_W], re_shift})
                   + $signed({{(SUM_W-Q_W){c_r_ff[Q_W-1]}}, c_r_ff});
   assign im_sum   = $signed({{(SUM_W-PROD_W){im_shift[PROD_W-1]}}, im_shift})
                   + $signed({{(SUM_W-Q_W){c_i_ff[Q_W-1]}}, c_i_ff});
   assign z_r_new  = sat_q(re_sum);
   assign z_i_new  = sat_q(im_sum);

   // The escape test is exact: the full squared magnitude against the limit scaled by 2^(2F).
   assign mag        = {1'b0, p_rr_ff} + {1'b0, p_ii_ff};
   assign mag_ext    = CMP_W'(mag);
   assign lim_scaled = CMP_W'(esc_limit_ff) << LIM_SHIFT;

   assign status.escaped    = mag_ext > lim_scaled;
   assign status.last_iter  = iter_ff == (iter_limit_ff - ITER_W'(1));
   assign status.limit_zero = iter_limit_ff == '0;

   always_comb begin
      c_r_in        = cmd.load ? req_c_real : c_r_ff;
      c_i_in        = cmd.load ? req_c_imag : c_i_ff;
      z_r_in        = z_r_ff;
      z_i_in        = z_i_ff;
      if (cmd.load) begin
         z_r_in = '0;
         z_i_in = '0;
      end else if (cmd.update) begin
         z_r_in = z_r_new;
         z_i_in = z_i_new;
      end
      p_rr_in       = p_rr_ff;
      p_ii_in       = p_ii_ff;
      p_ri_in       = p_ri_ff;
      if (cmd.mul) begin
         p_rr_in = z_r_ff * z_r_ff;
         p_ii_in = z_i_ff * z_i_ff;
         p_ri_in = z_r_ff * z_i_ff;
      end
      iter_in       = iter_ff;
      if (cmd.load) begin
         iter_in = '0;
      end else if (cmd.count) begin
         iter_in = iter_ff + ITER_W'(1);
      end
      res_in_set_in = res_in_set_ff;
      res_stop_in   = res_stop_ff;
      if (cmd.set_bounded) begin
         res_in_set_in = 1'b1;
         res_stop_in   = iter_limit_ff;
      end else if (cmd.set_escaped) begin
         res_in_set_in = 1'b0;
         res_stop_in   = iter_ff;
      end
      out_in_set_in = cmd.emit ? res_in_set_ff : out_in_set_ff;
      out_stop_in   = cmd.emit ? res_stop_ff : out_stop_ff;
   end

   assign rsp_in_set         = out_in_set_ff;
   assign rsp_stop_iteration = out_stop_ff;

   // Advancing the index never carries it to the limit itself.
   assert property (@(posedge clock) disable iff (reset)
      cmd.count |=> (iter_ff < iter_limit_ff))
      else $error("iteration index reached the limit while iterating");

endmodule

`default_nettype wire

>>> rtl/mandelbrot_escape_test_unit.sv
// Top level of the Mandelbrot escape-time unit: controller plus datapath.
// Depends on mbrot_pkg, mbrot_ctrl and mbrot_datapath.
//
// Usage: a point c (signed fixed point, FRAC_BITS fraction bits) is offered on the req_
// channel; one result (in_set, stop_iteration) comes back on the rsp_ channel. Both are
// valid/ready channels and a transfer happens when valid and ready are both high.
// The csr_ port writes the iteration limit (index 0) and the escape limit (index 1);
// write it only while no point is in flight.
// In each iteration ST_MUL registers the three 32x32 products of z, and ST_TEST then
// tests the squared magnitude and forms the new z from them. An item ends when it
// escapes or when its index reaches the last one the iteration limit allows; with a zero
// limit it is reported bounded without iterating.
// One point is worked on at a time; req_ready is high only while the unit is idle.
// The result sits in an output register, so a new point is accepted while an earlier
// result still waits; if the receiver stalls, the next finished result waits inside the
// unit until the output register is free.
// A synchronous reset returns the unit to idle, drops rsp_valid and restores the limits
// to 255 and 400.
`default_nettype none

module mandelbrot_escape_test_unit import mbrot_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_we,
   input  wire logic [CSR_IDX_W-1:0]   csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic signed [Q_W-1:0]  req_c_real,
   input  wire logic signed [Q_W-1:0]  req_c_imag,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic                        rsp_in_set,
   output logic [ITER_W-1:0]           rsp_stop_iteration
);

   cmd_type    cmd;
   status_type status;

   mbrot_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   mbrot_datapath #(
      .FRAC_BITS (FRAC_BITS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_c_real         (req_c_real),
      .req_c_imag         (req_c_imag),
      .cmd                (cmd),
      .status             (status),
      .rsp_in_set         (rsp_in_set),
      .rsp_stop_iteration (rsp_stop_iteration)
   );

endmodule

`default_nettype wire
